/* rtl/core/assert_macros.svh */
// Assertion macros used by the top level of the backlight core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, skipped while reset is high.
`define ASSERT_RST(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Checked property, also during reset.
`define ASSERT_ALL(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define ASSERT_RST(name, clk, rst, prop)
`define ASSERT_ALL(name, clk, prop)
`endif
`endif

/* rtl/core/bdpb_pkg.sv */
// Package with types, codes and reset values of the backlight core.
`timescale 1ns / 1ps
`default_nettype none
package bdpb_pkg;

   // Widths.
   localparam int TIME_BITS_DEF = 64;
   localparam int REG_BITS      = 40;
   localparam int ADDR_BITS     = 2;
   localparam int CMD_BITS      = 2;
   localparam int ACT_BITS      = 3;
   localparam int STAMP_BITS    = 64;
   localparam int RSP_BITS      = 8;

   // Command codes carried in the item's user field.
   localparam logic [CMD_BITS-1:0] CMD_PRESS   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd2;

   // Action codes of a result item.
   localparam logic [ACT_BITS-1:0] ACT_NONE    = 3'd0;
   localparam logic [ACT_BITS-1:0] ACT_TIMED   = 3'd1;
   localparam logic [ACT_BITS-1:0] ACT_LOCKED  = 3'd2;
   localparam logic [ACT_BITS-1:0] ACT_OFF     = 3'd3;
   localparam logic [ACT_BITS-1:0] ACT_TIMEOUT = 3'd4;

   // Register indexes.
   localparam logic [ADDR_BITS-1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [ADDR_BITS-1:0] REG_WINDOW   = 2'd1;
   localparam logic [ADDR_BITS-1:0] REG_HOLD     = 2'd2;

   // Register reset values in nanoseconds.
   localparam logic [REG_BITS-1:0] DEBOUNCE_RST = 40'd75000000;
   localparam logic [REG_BITS-1:0] WINDOW_RST   = 40'd1000000000;
   localparam logic [REG_BITS-1:0] HOLD_RST     = 40'd30000000000;

   // Configuration register set.
   typedef struct packed {
      logic [REG_BITS-1:0] debounce;
      logic [REG_BITS-1:0] window;
      logic [REG_BITS-1:0] hold;
   } cfg_type;

   // Control flags of the press detector.
   typedef struct packed {
      logic press_armed;
      logic release_seen;
      logic awaiting_second;
      logic toggle_turns_on;
      logic permanent_on;
      logic lit;
   } flags_type;

   localparam flags_type FLAGS_RST = '{
      press_armed:     1'b1,
      release_seen:    1'b0,
      awaiting_second: 1'b0,
      toggle_turns_on: 1'b0,
      permanent_on:    1'b0,
      lit:             1'b0
   };

endpackage
`default_nettype wire

/* rtl/core/bdpb_csr.sv */
// Configuration registers of the backlight core.
`timescale 1ns / 1ps
`default_nettype none
module bdpb_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_wen,
   input  wire logic [bdpb_pkg::ADDR_BITS-1:0] csr_addr,
   input  wire logic [bdpb_pkg::REG_BITS-1:0]  csr_wdata,
   output bdpb_pkg::cfg_type                  cfg
);

   bdpb_pkg::cfg_type cfg_ff;
   bdpb_pkg::cfg_type cfg_in;

   // Write decode; an index beyond the list changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            bdpb_pkg::REG_DEBOUNCE: cfg_in.debounce = csr_wdata;
            bdpb_pkg::REG_WINDOW:   cfg_in.window   = csr_wdata;
            bdpb_pkg::REG_HOLD:     cfg_in.hold     = csr_wdata;
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce <= bdpb_pkg::DEBOUNCE_RST;
         cfg_ff.window   <= bdpb_pkg::WINDOW_RST;
         cfg_ff.hold     <= bdpb_pkg::HOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* rtl/core/bdpb_eval.sv */
// Next-state and result logic for one button or tick item.
`timescale 1ns / 1ps
`default_nettype none
module bdpb_eval #(
   parameter int TIME_BITS = bdpb_pkg::TIME_BITS_DEF
) (
   input  wire logic [bdpb_pkg::CMD_BITS-1:0] cmd,
   input  wire logic [TIME_BITS-1:0]          t,
   input  wire bdpb_pkg::cfg_type             cfg,
   input  wire bdpb_pkg::flags_type           flags,
   input  wire logic [TIME_BITS-1:0]          last_release,
   input  wire logic [TIME_BITS-1:0]          first_press,
   input  wire logic [TIME_BITS-1:0]          off_deadline,
   output bdpb_pkg::flags_type                flags_nxt,
   output logic      [TIME_BITS-1:0]          last_release_nxt,
   output logic      [TIME_BITS-1:0]          first_press_nxt,
   output logic      [TIME_BITS-1:0]          off_deadline_nxt,
   output logic      [bdpb_pkg::ACT_BITS-1:0] action
);

   // Compare width holds both a time and a register value, plus a carry.
   localparam int W = ((TIME_BITS > bdpb_pkg::REG_BITS) ? TIME_BITS : bdpb_pkg::REG_BITS) + 1;

   logic [TIME_BITS-1:0] t_max;
   logic [TIME_BITS-1:0] rel_diff;
   logic [TIME_BITS-1:0] gap;
   logic [W-1:0]         dl_sum;
   logic [TIME_BITS-1:0] dl_sat;
   logic                 stable;
   logic                 counted;
   logic                 second;
   logic                 timeout;

   assign t_max = '1;

   // Debounce: the last release must be at least the debounce time old, if any was seen.
   assign rel_diff = t - last_release;
   assign stable   = !flags.release_seen ||
                     ((t >= last_release) &&
                      (W'(rel_diff) >= W'(cfg.debounce)));
   assign counted  = flags.press_armed && stable;

   // Second press inside the window; the gap wraps around.
   assign gap    = t - first_press;
   assign second = flags.awaiting_second && (W'(gap) <= W'(cfg.window));

   // Deadline of a single press, saturated at the largest time.
   assign dl_sum = W'(t) + W'(cfg.hold);
   assign dl_sat = (dl_sum > W'(t_max)) ? t_max : dl_sum[TIME_BITS-1:0];

   assign timeout = flags.lit && !flags.permanent_on && (t >= off_deadline);

   always_comb begin
      flags_nxt        = flags;
      last_release_nxt = last_release;
      first_press_nxt  = first_press;
      off_deadline_nxt = off_deadline;
      action           = bdpb_pkg::ACT_NONE;
      case (cmd)
         bdpb_pkg::CMD_RELEASE: begin
            flags_nxt.press_armed  = 1'b1;
            flags_nxt.release_seen = 1'b1;
            last_release_nxt       = t;
         end
         bdpb_pkg::CMD_PRESS: begin
            flags_nxt.press_armed = 1'b0;
            if (counted) begin
               if (second) begin
                  flags_nxt.awaiting_second = 1'b0;
                  flags_nxt.permanent_on    = flags.toggle_turns_on;
                  flags_nxt.lit             = flags.toggle_turns_on;
                  action = flags.toggle_turns_on ? bdpb_pkg::ACT_LOCKED
                                                 : bdpb_pkg::ACT_OFF;
               end else begin
                  flags_nxt.awaiting_second = 1'b1;
                  flags_nxt.toggle_turns_on = !flags.permanent_on;
                  flags_nxt.permanent_on    = 1'b0;
                  flags_nxt.lit             = 1'b1;
                  first_press_nxt           = t;
                  off_deadline_nxt          = dl_sat;
                  action                    = bdpb_pkg::ACT_TIMED;
               end
            end
         end
         bdpb_pkg::CMD_TICK: begin
            if (timeout) begin
               flags_nxt.lit = 1'b0;
               action        = bdpb_pkg::ACT_TIMEOUT;
            end
         end
         default: action = bdpb_pkg::ACT_NONE;
      endcase
   end

endmodule
`default_nettype wire

/* rtl/core/button_double_press_backlight_core.sv */
// Top level of the debounced double-press backlight core.
//
//   channel  direction  handshake             payload
//   req      in         req_tvalid/req_tready tuser[1:0] cmd, tdata[63:0] time_ns
//   rsp      out        rsp_tvalid/rsp_tready tdata[0] lit, [1] locked_on, [4:2] action
//   csr      in         csr_wen (no wait)     csr_addr register index, csr_wdata value
//
// An item is held in the input register, then its result sits in the
// output register; one item per cycle is sustained while rsp_tready is high.
// The state update and the result are one pass of compares and adds on the
// input register, so the next item sees the new state at once.
// A stalled result register holds; the input register still takes one item.
// Synchronous reset restores the register defaults and the idle detector state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module button_double_press_backlight_core #(
   parameter int TIME_BITS = bdpb_pkg::TIME_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // tdata: time_ns
   input  wire logic [bdpb_pkg::STAMP_BITS-1:0] req_tdata,
   // tuser: cmd
   input  wire logic [bdpb_pkg::CMD_BITS-1:0]   req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // tdata: backlight_lit, locked_on, action, zero fill
   output logic      [bdpb_pkg::RSP_BITS-1:0]   rsp_tdata,
   input  wire logic                            csr_wen,
   input  wire logic [bdpb_pkg::ADDR_BITS-1:0]  csr_addr,
   input  wire logic [bdpb_pkg::REG_BITS-1:0]   csr_wdata
);

   bdpb_pkg::cfg_type   cfg;
   bdpb_pkg::flags_type flags_ff, flags_in, flags_nxt;

   logic                          s1_valid_ff, s1_valid_in;
   logic [bdpb_pkg::CMD_BITS-1:0] s1_cmd_ff, s1_cmd_in;
   logic [TIME_BITS-1:0]          s1_time_ff, s1_time_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bdpb_pkg::RSP_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [TIME_BITS-1:0] last_release_ff, last_release_in, last_release_nxt;
   logic [TIME_BITS-1:0] first_press_ff, first_press_in, first_press_nxt;
   logic [TIME_BITS-1:0] off_deadline_ff, off_deadline_in, off_deadline_nxt;
   logic [bdpb_pkg::ACT_BITS-1:0] action;

   logic req_fire;
   logic s1_go;

   bdpb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdpb_eval #(.TIME_BITS(TIME_BITS)) u_eval (
      .cmd              (s1_cmd_ff),
      .t                (s1_time_ff),
      .cfg              (cfg),
      .flags            (flags_ff),
      .last_release     (last_release_ff),
      .first_press      (first_press_ff),
      .off_deadline     (off_deadline_ff),
      .flags_nxt        (flags_nxt),
      .last_release_nxt (last_release_nxt),
      .first_press_nxt  (first_press_nxt),
      .off_deadline_nxt (off_deadline_nxt),
      .action           (action)
   );

   // Handshake: the input register moves on when the result register frees up.
   assign s1_go      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;
   assign req_fire   = req_tvalid && req_tready;

   // Input register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_cmd_in   = s1_cmd_ff;
      s1_time_in  = s1_time_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_cmd_in   = req_tuser;
         s1_time_in  = req_tdata[TIME_BITS-1:0];
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // Detector state advances once per item leaving the input register.
   always_comb begin
      flags_in        = flags_ff;
      last_release_in = last_release_ff;
      first_press_in  = first_press_ff;
      off_deadline_in = off_deadline_ff;
      if (s1_go) begin
         flags_in        = flags_nxt;
         last_release_in = last_release_nxt;
         first_press_in  = first_press_nxt;
         off_deadline_in = off_deadline_nxt;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_go) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, action, flags_nxt.permanent_on, flags_nxt.lit};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         flags_ff        <= bdpb_pkg::FLAGS_RST;
         last_release_ff <= '0;
         first_press_ff  <= '0;
         off_deadline_ff <= '0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         flags_ff        <= flags_in;
         last_release_ff <= last_release_in;
         first_press_ff  <= first_press_in;
         off_deadline_ff <= off_deadline_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= s1_cmd_in;
      s1_time_ff  <= s1_time_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A locked backlight is always lit.
   `ASSERT_RST(a_locked_lit, clock, reset, flags_ff.permanent_on |-> flags_ff.lit)
   // A full input register behind a stalled result takes no item.
   `ASSERT_RST(a_stall_blocks, clock, reset,
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
   // A timeout result reports the light off.
   `ASSERT_RST(a_timeout_dark, clock, reset,
      (rsp_tvalid && (rsp_tdata[4:2] == bdpb_pkg::ACT_TIMEOUT)) |-> !rsp_tdata[0])
   // A lock result reports the light locked and lit.
   `ASSERT_RST(a_lock_lit, clock, reset,
      (rsp_tvalid && (rsp_tdata[4:2] == bdpb_pkg::ACT_LOCKED)) |-> (rsp_tdata[1] && rsp_tdata[0]))
   // Waiting for a second press starts only on a press item.
   `ASSERT_RST(a_wait_from_press, clock, reset,
      $rose(flags_ff.awaiting_second) |->
         ($past(s1_go) && ($past(s1_cmd_ff) == bdpb_pkg::CMD_PRESS)))

endmodule
`default_nettype wire
